### rtl/dfd_pkg.sv
// Shared types, constants and decode functions of the readout frame decoder.
// No dependencies; every rtl file imports this package.
package dfd_pkg;

  localparam int DATA_WORDS = 32;
  localparam int NUM_PIXELS = 32;
  localparam int WORD_AW    = $clog2(DATA_WORDS);
  localparam int NUM_BANKS  = 2;
  localparam int BANK_W     = $clog2(NUM_BANKS);
  localparam int MEM_AW     = BANK_W + WORD_AW;
  localparam int PIX_W      = $clog2(NUM_PIXELS);
  localparam int ROW_W      = 30;
  localparam int ELEM_W     = 10;
  localparam int COARSE_W   = 9;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [27:0] HDR_KEY     = 28'h8000000;
  localparam logic [31:0] FOOTER_WORD = 32'hC000_0000;

  // Element position inside a 30-bit row word
  typedef enum logic [1:0] {
    POS_HI  = 2'd0,
    POS_MID = 2'd1,
    POS_LO  = 2'd2
  } elem_pos_t;

  typedef struct packed {
    logic [BANK_W-1:0] bank;
    logic [3:0]        asic;
    logic [31:0]       t0;
    logic [63:0]       run;
    logic [31:0]       evt;
  } frame_desc_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [ROW_W-1:0]  data;
  } row_wr_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr_a;
    logic [MEM_AW-1:0] addr_b;
  } row_rd_t;

  function automatic logic [ELEM_W-1:0] row_elem(input logic [ROW_W-1:0] w,
                                                 input elem_pos_t pos);
    logic [ELEM_W-1:0] e;
    case (pos)
      POS_HI:  e = w[29:20];
      POS_MID: e = w[19:10];
      POS_LO:  e = w[9:0];
      default: e = w[9:0];
    endcase
    return e;
  endfunction

  function automatic logic [ELEM_W-1:0] gray10(input logic [ELEM_W-1:0] g);
    logic [ELEM_W-1:0] t;
    t = g ^ (g >> 8);
    t = t ^ (t >> 4);
    t = t ^ (t >> 2);
    t = t ^ (t >> 1);
    return t;
  endfunction

  function automatic logic [COARSE_W-1:0] gray9(input logic [COARSE_W-1:0] g);
    logic [COARSE_W-1:0] t;
    t = g ^ (g >> 8);
    t = t ^ (t >> 4);
    t = t ^ (t >> 2);
    t = t ^ (t >> 1);
    return t;
  endfunction

endpackage

### rtl/dfd_front.sv
// Frame parser: hunts headers, latches header words, writes data rows into
// the row memory and posts a frame descriptor on a good footer. Uses dfd_pkg.
module dfd_front import dfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic [31:0] word,
  output row_wr_t     wr,
  output logic        desc_push,
  output frame_desc_t desc
);

  typedef enum logic [6:0] {
    PH_HUNT   = 7'b0000001,
    PH_T0     = 7'b0000010,
    PH_RUN_LO = 7'b0000100,
    PH_RUN_HI = 7'b0001000,
    PH_EVENT  = 7'b0010000,
    PH_DATA   = 7'b0100000,
    PH_FOOTER = 7'b1000000
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [3:0]          asic_r, asic_nxt;
  logic [31:0]         t0_r, t0_nxt;
  logic [63:0]         run_r, run_nxt;
  logic [31:0]         evt_r, evt_nxt;
  logic [WORD_AW-1:0]  cnt_r, cnt_nxt;
  logic [BANK_W-1:0]   bank_r, bank_nxt;

  always_comb begin
    phase_nxt = phase_r;
    asic_nxt  = asic_r;
    t0_nxt    = t0_r;
    run_nxt   = run_r;
    evt_nxt   = evt_r;
    cnt_nxt   = cnt_r;
    bank_nxt  = bank_r;
    wr.en     = 1'b0;
    wr.addr   = {bank_r, cnt_r};
    wr.data   = word[ROW_W-1:0];
    desc_push = 1'b0;
    if (acc) begin
      case (phase_r)
        PH_T0: begin
          t0_nxt    = word;
          phase_nxt = PH_RUN_LO;
        end
        PH_RUN_LO: begin
          run_nxt   = {32'd0, word};
          phase_nxt = PH_RUN_HI;
        end
        PH_RUN_HI: begin
          run_nxt   = {word, run_r[31:0]};
          phase_nxt = PH_EVENT;
        end
        PH_EVENT: begin
          evt_nxt   = word;
          cnt_nxt   = '0;
          phase_nxt = PH_DATA;
        end
        PH_DATA: begin
          wr.en   = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == WORD_AW'(DATA_WORDS - 1)) begin
            phase_nxt = PH_FOOTER;
          end
        end
        PH_FOOTER: begin
          // post the frame and flip banks; a bad footer just drops it
          if (word == FOOTER_WORD) begin
            desc_push = 1'b1;
            bank_nxt  = bank_r + 1'b1;
          end
          phase_nxt = PH_HUNT;
        end
        default: begin
          if (word[31:4] == HDR_KEY) begin
            asic_nxt  = word[3:0];
            cnt_nxt   = '0;
            phase_nxt = PH_T0;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
      endcase
    end
  end

  assign desc.bank = bank_r;
  assign desc.asic = asic_r;
  assign desc.t0   = t0_r;
  assign desc.run  = run_r;
  assign desc.evt  = evt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      asic_r  <= '0;
      t0_r    <= '0;
      run_r   <= '0;
      evt_r   <= '0;
      cnt_r   <= '0;
      bank_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      asic_r  <= asic_nxt;
      t0_r    <= t0_nxt;
      run_r   <= run_nxt;
      evt_r   <= evt_nxt;
      cnt_r   <= cnt_nxt;
      bank_r  <= bank_nxt;
    end
  end

endmodule

### rtl/dfd_row_mem.sv
// Double-banked row memory: one write port, two registered read ports.
// Uses dfd_pkg for widths and port structs.
module dfd_row_mem import dfd_pkg::*; (
  input  logic             clk,
  input  row_wr_t          wr,
  input  row_rd_t          rd,
  output logic [ROW_W-1:0] rd_a,
  output logic [ROW_W-1:0] rd_b
);

  logic [ROW_W-1:0] mem_r [2**MEM_AW];
  logic [ROW_W-1:0] rd_a_r;
  logic [ROW_W-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  // hold read data while the reader stalls
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_a_r <= mem_r[rd.addr_a];
      rd_b_r <= mem_r[rd.addr_b];
    end
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

### rtl/dfd_desc_queue.sv
// Two-entry queue of frame descriptors between parser and pixel emitter.
// Uses dfd_pkg for the descriptor type and depth.
module dfd_desc_queue import dfd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_en,
  input  frame_desc_t        push_desc,
  input  logic               pop_en,
  output frame_desc_t        head,
  output logic [Q_CNT_W-1:0] count
);

  frame_desc_t          ent_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wptr_r, rptr_r;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_en && !pop_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_en && !push_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      ent_r[wptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push_en) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop_en) begin
        rptr_r <= rptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign head  = ent_r[rptr_r];
  assign count = cnt_r;

endmodule

### rtl/dfd_back.sv
// Pixel emitter: walks the 32 pixels of the head frame, reads row words,
// gray-decodes the elements and drives the result register. Uses dfd_pkg.
module dfd_back import dfd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_vld,
  input  frame_desc_t         head,
  output logic                head_pop,
  output row_rd_t             rd,
  input  logic [ROW_W-1:0]    rd_a,
  input  logic [ROW_W-1:0]    rd_b,
  output logic                empty,
  input  logic                pop,
  output logic [3:0]          out_asic_id,
  output logic [31:0]         out_t0_timestamp,
  output logic [63:0]         out_run_timestamp,
  output logic [31:0]         out_event_num,
  output logic [PIX_W-1:0]    out_pixel_index,
  output logic                out_hit,
  output logic [ELEM_W-1:0]   out_charge,
  output logic [ELEM_W-1:0]   out_fine_time,
  output logic [COARSE_W-1:0] out_coarse_time,
  output logic                out_last_pixel
);

  // coarse elements start at element 2*NUM_PIXELS
  localparam int CB_WORD = (2 * NUM_PIXELS) / 3;
  localparam int CB_POS  = (2 * NUM_PIXELS) % 3;

  // issue counters: charge element 2i+1 and coarse element 64+i
  logic [PIX_W-1:0]   pix_r, pix_nxt;
  logic [WORD_AW-1:0] wa_r, wa_nxt, wb_r, wb_nxt;
  elem_pos_t          pa_r, pa_nxt, pb_r, pb_nxt;

  logic               s1_vld_r;
  logic [PIX_W-1:0]   s1_pix_r;
  elem_pos_t          s1_pa_r, s1_pb_r;
  frame_desc_t        s1_hdr_r;
  logic [ROW_W-1:0]   prev_a_r;

  logic               out_vld_r;
  frame_desc_t        out_hdr_r;
  logic [PIX_W-1:0]   out_pix_r;
  logic               out_hit_r;
  logic [ELEM_W-1:0]  out_charge_r, out_fine_r;
  logic [COARSE_W-1:0] out_coarse_r;

  logic               out_take, s1_adv, s1_rdy, issue, last_issue;
  logic [ELEM_W-1:0]  charge_e, fine_e, coarse_e;

  assign out_take   = out_vld_r && pop;
  assign s1_adv     = s1_vld_r && (!out_vld_r || pop);
  assign s1_rdy     = !s1_vld_r || s1_adv;
  assign issue      = head_vld && s1_rdy;
  assign last_issue = issue && (pix_r == PIX_W'(NUM_PIXELS - 1));
  assign head_pop   = last_issue;

  assign rd.en     = issue;
  assign rd.addr_a = {head.bank, wa_r};
  assign rd.addr_b = {head.bank, wb_r};

  always_comb begin
    pix_nxt = pix_r;
    wa_nxt  = wa_r;
    pa_nxt  = pa_r;
    wb_nxt  = wb_r;
    pb_nxt  = pb_r;
    if (last_issue) begin
      pix_nxt = '0;
      wa_nxt  = '0;
      pa_nxt  = POS_MID;
      wb_nxt  = WORD_AW'(CB_WORD);
      pb_nxt  = elem_pos_t'(CB_POS);
    end else if (issue) begin
      pix_nxt = pix_r + 1'b1;
      // advance charge element by two positions
      case (pa_r)
        POS_HI:  pa_nxt = POS_LO;
        POS_MID: begin
          pa_nxt = POS_HI;
          wa_nxt = wa_r + 1'b1;
        end
        default: begin
          pa_nxt = POS_MID;
          wa_nxt = wa_r + 1'b1;
        end
      endcase
      // advance coarse element by one position
      case (pb_r)
        POS_HI:  pb_nxt = POS_MID;
        POS_MID: pb_nxt = POS_LO;
        default: begin
          pb_nxt = POS_HI;
          wb_nxt = wb_r + 1'b1;
        end
      endcase
    end
  end

  // fine element sits one before charge; at a word start it is in the prior word
  always_comb begin
    charge_e = row_elem(rd_a, s1_pa_r);
    coarse_e = row_elem(rd_b, s1_pb_r);
    case (s1_pa_r)
      POS_HI:  fine_e = row_elem(prev_a_r, POS_LO);
      POS_MID: fine_e = row_elem(rd_a, POS_HI);
      default: fine_e = row_elem(rd_a, POS_MID);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r     <= '0;
      wa_r      <= '0;
      pa_r      <= POS_MID;
      wb_r      <= WORD_AW'(CB_WORD);
      pb_r      <= elem_pos_t'(CB_POS);
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      pix_r <= pix_nxt;
      wa_r  <= wa_nxt;
      pa_r  <= pa_nxt;
      wb_r  <= wb_nxt;
      pb_r  <= pb_nxt;
      if (issue) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_take) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_pix_r <= pix_r;
      s1_pa_r  <= pa_r;
      s1_pb_r  <= pb_r;
      s1_hdr_r <= head;
    end
    if (s1_adv) begin
      prev_a_r     <= rd_a;
      out_hdr_r    <= s1_hdr_r;
      out_pix_r    <= s1_pix_r;
      out_hit_r    <= coarse_e[0];
      out_charge_r <= gray10(charge_e);
      out_fine_r   <= gray10(fine_e);
      out_coarse_r <= gray9(coarse_e[ELEM_W-1:1]);
    end
  end

  assign empty             = !out_vld_r;
  assign out_asic_id       = out_hdr_r.asic;
  assign out_t0_timestamp  = out_hdr_r.t0;
  assign out_run_timestamp = out_hdr_r.run;
  assign out_event_num     = out_hdr_r.evt;
  assign out_pixel_index   = out_pix_r;
  assign out_hit           = out_hit_r;
  assign out_charge        = out_charge_r;
  assign out_fine_time     = out_fine_r;
  assign out_coarse_time   = out_coarse_r;
  assign out_last_pixel    = (out_pix_r == PIX_W'(NUM_PIXELS - 1));

endmodule

### rtl/detector_frame_decoder.sv
// Readout frame decoder top level: parser, row memory, descriptor queue and
// pixel emitter. Depends on dfd_pkg and all dfd_* modules.
//
// Usage:
//   Input side is a queue write port: drive in_data_word and push; a word is
//   taken on a clock edge with push high and full low. One readout word per
//   cycle is accepted while full is low. full rises only while both
//   row-memory banks hold parsed frames that have not yet been emitted.
//   Result side is a queue read port: while empty is low the oldest pixel
//   result sits on the out_* ports; pop high on an edge takes it.
//   A good footer yields 32 pixel results, one per cycle while pop is
//   high; the first passes the queue count, the read stage and the output
//   register before it shows. A frame carries 38 input words and 32 pixel
//   results, so with a free receiver the input never stalls. The emit
//   rate is set by the two-port row memory read, one pixel per cycle.
//   When pop stays low the emitter holds, the descriptor queue fills and,
//   once two frames wait, full holds the input.
//   Reset (rst_n low, synchronous) returns the parser to header hunting and
//   empties the queue and the output register; row memory is not cleared.
module detector_frame_decoder import dfd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic [31:0]         in_data_word,
  output logic                empty,
  input  logic                pop,
  output logic [3:0]          out_asic_id,
  output logic [31:0]         out_t0_timestamp,
  output logic [63:0]         out_run_timestamp,
  output logic [31:0]         out_event_num,
  output logic [PIX_W-1:0]    out_pixel_index,
  output logic                out_hit,
  output logic [ELEM_W-1:0]   out_charge,
  output logic [ELEM_W-1:0]   out_fine_time,
  output logic [COARSE_W-1:0] out_coarse_time,
  output logic                out_last_pixel
);

  logic               acc;
  row_wr_t            wr;
  row_rd_t            rd;
  logic               desc_push, desc_pop;
  frame_desc_t        desc, head;
  logic [Q_CNT_W-1:0] q_count;
  logic [ROW_W-1:0]   rd_a, rd_b;

  assign full = (q_count == Q_CNT_W'(Q_DEPTH));
  assign acc  = push && !full;

  dfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .word      (in_data_word),
    .wr        (wr),
    .desc_push (desc_push),
    .desc      (desc)
  );

  dfd_row_mem u_row_mem (
    .clk  (clk),
    .wr   (wr),
    .rd   (rd),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  dfd_desc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (desc_push),
    .push_desc (desc),
    .pop_en    (desc_pop),
    .head      (head),
    .count     (q_count)
  );

  dfd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_vld          (q_count != '0),
    .head              (head),
    .head_pop          (desc_pop),
    .rd                (rd),
    .rd_a              (rd_a),
    .rd_b              (rd_b),
    .empty             (empty),
    .pop               (pop),
    .out_asic_id       (out_asic_id),
    .out_t0_timestamp  (out_t0_timestamp),
    .out_run_timestamp (out_run_timestamp),
    .out_event_num     (out_event_num),
    .out_pixel_index   (out_pixel_index),
    .out_hit           (out_hit),
    .out_charge        (out_charge),
    .out_fine_time     (out_fine_time),
    .out_coarse_time   (out_coarse_time),
    .out_last_pixel    (out_last_pixel)
  );

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> empty && (q_count == '0))
    else $error("reset did not clear queue and result register");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= Q_CNT_W'(Q_DEPTH))
    else $error("descriptor queue count out of range");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    desc_pop |-> (q_count != '0))
    else $error("descriptor popped from an empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    desc_push |-> !full)
    else $error("descriptor pushed into a full queue");

endmodule

### tb/tb.sv
// Testbench for detector_frame_decoder: pushes readout words, predicts the
// pixel results of each frame and checks them in order. Depends on dfd_pkg.
`timescale 1ns / 1ps
module tb;
  import dfd_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 8;

  typedef enum logic [2:0] {
    FP_HUNT,
    FP_T0,
    FP_RUN_LO,
    FP_RUN_HI,
    FP_EVENT,
    FP_DATA,
    FP_FOOTER
  } frame_phase_t;

  typedef enum int {
    FILL_ZERO,
    FILL_ONES,
    FILL_RANDOM
  } fill_t;

  typedef struct packed {
    logic [3:0]          asic;
    logic [31:0]         t0;
    logic [63:0]         run;
    logic [31:0]         evt;
    logic [PIX_W-1:0]    pix;
    logic                hit;
    logic [ELEM_W-1:0]   charge;
    logic [ELEM_W-1:0]   fine;
    logic [COARSE_W-1:0] coarse;
    logic                last;
  } pixel_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                push = 1'b0;
  logic                full;
  logic [31:0]         in_data_word = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [3:0]          out_asic_id;
  logic [31:0]         out_t0_timestamp;
  logic [63:0]         out_run_timestamp;
  logic [31:0]         out_event_num;
  logic [PIX_W-1:0]    out_pixel_index;
  logic                out_hit;
  logic [ELEM_W-1:0]   out_charge;
  logic [ELEM_W-1:0]   out_fine_time;
  logic [COARSE_W-1:0] out_coarse_time;
  logic                out_last_pixel;

  // Parser state mirrored by the predictor
  frame_phase_t phase = FP_HUNT;
  int           row_count = 0;
  logic [3:0]   frame_asic = '0;
  logic [31:0]  frame_t0 = '0;
  logic [63:0]  frame_run = '0;
  logic [31:0]  frame_evt = '0;
  logic [29:0]  rows [DATA_WORDS];

  pixel_t pixel_q[$];
  int     err_count = 0;
  int     cycles = 0;
  int     tx_idle_pct = 0;
  int     rx_stall_pct = 0;
  logic   rx_hold = 1'b0;
  event   hold_go;

  detector_frame_decoder DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_data_word     (in_data_word),
    .empty            (empty),
    .pop              (pop),
    .out_asic_id      (out_asic_id),
    .out_t0_timestamp (out_t0_timestamp),
    .out_run_timestamp(out_run_timestamp),
    .out_event_num    (out_event_num),
    .out_pixel_index  (out_pixel_index),
    .out_hit          (out_hit),
    .out_charge       (out_charge),
    .out_fine_time    (out_fine_time),
    .out_coarse_time  (out_coarse_time),
    .out_last_pixel   (out_last_pixel)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic logic [ELEM_W-1:0] ungray(input logic [ELEM_W-1:0] g);
    logic [ELEM_W-1:0] b;
    int k;
    b[ELEM_W-1] = g[ELEM_W-1];
    for (k = ELEM_W - 2; k >= 0; k--) b[k] = b[k+1] ^ g[k];
    return b;
  endfunction

  // Element e sits in row word e/3, highest slice first
  function automatic logic [ELEM_W-1:0] row_field(input int e);
    logic [29:0] w;
    int sh;
    w = rows[e / 3];
    sh = (2 - e % 3) * 10;
    return w[sh +: 10];
  endfunction

  task automatic decode_word(input logic [31:0] w);
    pixel_t px;
    logic [ELEM_W-1:0] ce;
    logic [ELEM_W-1:0] cd;
    int i;
    case (phase)
      FP_T0: begin
        frame_t0 = w;
        phase = FP_RUN_LO;
      end
      FP_RUN_LO: begin
        frame_run = {32'd0, w};
        phase = FP_RUN_HI;
      end
      FP_RUN_HI: begin
        frame_run[63:32] = w;
        phase = FP_EVENT;
      end
      FP_EVENT: begin
        frame_evt = w;
        row_count = 0;
        phase = FP_DATA;
      end
      FP_DATA: begin
        rows[row_count] = w[29:0];
        row_count++;
        if (row_count >= DATA_WORDS) phase = FP_FOOTER;
      end
      FP_FOOTER: begin
        if (w == FOOTER_WORD) begin
          for (i = 0; i < NUM_PIXELS; i++) begin
            ce = row_field(64 + i);
            cd = ungray({1'b0, ce[9:1]});
            px.asic   = frame_asic;
            px.t0     = frame_t0;
            px.run    = frame_run;
            px.evt    = frame_evt;
            px.pix    = i[PIX_W-1:0];
            px.hit    = ce[0];
            px.charge = ungray(row_field(2 * i + 1));
            px.fine   = ungray(row_field(2 * i));
            px.coarse = cd[COARSE_W-1:0];
            px.last   = (i == NUM_PIXELS - 1);
            pixel_q.push_back(px);
          end
        end
        phase = FP_HUNT;
      end
      default: begin
        if (w[31:4] == HDR_KEY) begin
          frame_asic = w[3:0];
          row_count = 0;
          phase = FP_T0;
        end else begin
          phase = FP_HUNT;
        end
      end
    endcase
  endtask

  task automatic report_error(input string msg);
    $display("ERROR @%0d: %s", cycles, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input int pix, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_error($sformatf("pixel %0d %s got %0h want %0h", pix, name, got, want));
  endtask

  // Receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (rx_hold) pop <= 1'b0;
    else pop <= ($urandom_range(99, 0) >= rx_stall_pct);
  end

  always begin
    @(hold_go);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && pop && !empty) begin
      if (pixel_q.size() == 0) begin
        report_error("pixel result with nothing expected");
      end else begin
        want = pixel_q.pop_front();
        check_field("asic_id", want.pix, out_asic_id, want.asic);
        check_field("t0_timestamp", want.pix, out_t0_timestamp, want.t0);
        check_field("run_timestamp", want.pix, out_run_timestamp, want.run);
        check_field("event_num", want.pix, out_event_num, want.evt);
        check_field("pixel_index", want.pix, out_pixel_index, want.pix);
        check_field("hit", want.pix, out_hit, want.hit);
        check_field("charge", want.pix, out_charge, want.charge);
        check_field("fine_time", want.pix, out_fine_time, want.fine);
        check_field("coarse_time", want.pix, out_coarse_time, want.coarse);
        check_field("last_pixel", want.pix, out_last_pixel, want.last);
      end
    end
  end

  // Hold push high across back-to-back transactions; lower it only in gaps
  task automatic send_word(input logic [31:0] w);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_data_word <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    decode_word(w);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] frame_word(input fill_t kind);
    logic [3:0] id;
    id = 4'($urandom_range(15, 0));
    case (kind)
      FILL_ZERO: return '0;
      FILL_ONES: return '1;
      default: begin
        // Mix in header and footer patterns; inside a frame they are plain data
        case ($urandom_range(15, 0))
          0: return {HDR_KEY, id};
          1: return FOOTER_WORD;
          2: return '0;
          3: return '1;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  task automatic send_frame(input logic [3:0] asic, input fill_t kind,
                            input logic [31:0] footer);
    send_word({HDR_KEY, asic});
    repeat (4 + DATA_WORDS) send_word(frame_word(kind));
    send_word(footer);
  endtask

  task automatic run_frames(input int n_frames, input bit allow_bad);
    logic [31:0] footer;
    logic [3:0] id;
    int f;
    for (f = 0; f < n_frames; f++) begin
      repeat ($urandom_range(2, 0)) send_word(frame_word(FILL_RANDOM));
      id = 4'($urandom_range(15, 0));
      footer = FOOTER_WORD;
      if (allow_bad && $urandom_range(5, 0) == 0) begin
        case ($urandom_range(2, 0))
          0: footer = $urandom;
          1: footer = {HDR_KEY, id};
          default: footer = FOOTER_WORD ^ (32'd1 << $urandom_range(31, 0));
        endcase
      end
      send_frame(id, FILL_RANDOM, footer);
    end
  endtask

  task automatic test_hunt_noise();
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(FOOTER_WORD);
    send_word(32'h7FFF_FFFF);
    send_word(32'h8000_0010);
    send_word(32'h8800_0000);
    send_word(32'h0000_0001);
    send_word(32'h4000_0000);
    send_word(32'hFFFF_FFF0);
    send_word(32'h8000_0100);
    drain();
  endtask

  task automatic test_extreme_frames();
    send_frame(4'h0, FILL_ZERO, FOOTER_WORD);
    send_frame(4'hF, FILL_ONES, FOOTER_WORD);
    // Header-shaped bad footer: drop it, do not restart on it
    send_frame(4'h5, FILL_RANDOM, {HDR_KEY, 4'h9});
    send_frame(4'hA, FILL_RANDOM, FOOTER_WORD ^ 32'd1);
    send_frame(4'h3, FILL_RANDOM, FOOTER_WORD);
    drain();
  endtask

  task automatic test_no_idle();
    tx_idle_pct = 0;
    rx_stall_pct <= 0;
    run_frames(1, 1'b1);
    drain();
  endtask

  task automatic test_sender_idle();
    tx_idle_pct = 83;
    rx_stall_pct <= 0;
    run_frames(1, 1'b1);
    drain();
  endtask

  task automatic test_receiver_stall();
    tx_idle_pct = 0;
    rx_stall_pct <= 83;
    run_frames(1, 1'b1);
    drain();
  endtask

  task automatic test_both_idle();
    tx_idle_pct = 17;
    rx_stall_pct <= 17;
    run_frames(1, 1'b1);
    drain();
  endtask

  // Hold off the receiver while good frames stream in, so both banks fill
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct <= 0;
    -> hold_go;
    run_frames(3, 1'b0);
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_hunt_noise();
    test_extreme_frames();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_backpressure();
    if (err_count == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule
